/* rtl/core/dtf_pkg.sv */
// Shared constants, types and a helper function of the decimal text to fixed-point unit.
`timescale 1ns / 1ps

package dtf_pkg;

  // Widths of the fraction_digits register, of the whole-part accumulator and of the result.
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned WHOLE_W = 31;
  localparam int unsigned VALUE_W = 32;

  // Default for the largest number of decimal places kept.
  localparam int unsigned MAX_FRACTION_DIGITS_DEF = 6;

  // Largest magnitude accepted for the whole part and for the scaled result.
  localparam logic [63:0] LIMIT = 64'd2000000000;

  // Register index of fraction_digits on the configuration port.
  localparam logic REG_FRACTION_DIGITS = 1'b0;

  // Characters of the number text.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Parser position within the text.
  typedef enum logic [1:0] {
    PH_START,
    PH_WHOLE,
    PH_FRAC
  } phase_e;

  // Powers of ten up to 10^9.
  function automatic logic [63:0] pow10(input logic [3:0] e);
    logic [63:0] p;
    case (e)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

/* rtl/core/dtf_scale.sv */
// Result pipeline: scales the whole and fraction parts, checks the range and applies the sign.
`timescale 1ns / 1ps

module dtf_scale
  import dtf_pkg::*;
#(
  parameter int unsigned FRAC_W = 20,
  parameter int unsigned POW_W  = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // End-of-text request from the parser
  input  logic                       req_valid_i,
  output logic                       req_stall_o,
  input  logic [WHOLE_W-1:0]         whole_i,
  input  logic [FRAC_W-1:0]          frac_i,
  input  logic [POW_W-1:0]           whole_scale_i,
  input  logic [POW_W-1:0]           frac_scale_i,
  input  logic                       negative_i,
  input  logic                       ok_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [VALUE_W-1:0]  value_o,
  output logic                       ok_o
);

  localparam int unsigned PW_W  = WHOLE_W + POW_W;
  localparam int unsigned PF_W  = FRAC_W + POW_W;
  localparam int unsigned SUM_W = PW_W + 1;

  // Stage occupancy and per-stage advance conditions.
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_load, s2_load, s1_load;

  assign out_load    = !out_valid_q || !out_stall_i;
  assign s2_load     = !s2_valid_q || out_load;
  assign s1_load     = !s1_valid_q || s2_load;
  assign req_stall_o = !s1_load;

  // Stage 1: operands captured from the parser.
  logic [WHOLE_W-1:0] s1_whole_q;
  logic [FRAC_W-1:0]  s1_frac_q;
  logic [POW_W-1:0]   s1_wscale_q, s1_fscale_q;
  logic               s1_neg_q, s1_ok_q;

  // Stage 2: products.
  logic [PW_W-1:0]    s2_pw_q;
  logic [PF_W-1:0]    s2_pf_q;
  logic               s2_neg_q, s2_ok_q;

  // Output register.
  logic [VALUE_W-1:0] value_q;
  logic               ok_q;

  // Range check and sign on the summed magnitude.
  logic [SUM_W-1:0]   sum;
  logic               in_range;
  logic [VALUE_W-1:0] value_d;
  logic               ok_d;

  always_comb begin
    sum      = SUM_W'(s2_pw_q) + SUM_W'(s2_pf_q);
    in_range = (sum <= SUM_W'(LIMIT));
    ok_d     = s2_ok_q && in_range;
    if (!ok_d) begin
      value_d = '0;
    end else if (s2_neg_q) begin
      value_d = VALUE_W'(0) - sum[VALUE_W-1:0];
    end else begin
      value_d = sum[VALUE_W-1:0];
    end
  end

  // Valid flags of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= req_valid_i;
      end
      if (s2_load) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_load) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    if (s1_load && req_valid_i) begin
      s1_whole_q  <= whole_i;
      s1_frac_q   <= frac_i;
      s1_wscale_q <= whole_scale_i;
      s1_fscale_q <= frac_scale_i;
      s1_neg_q    <= negative_i;
      s1_ok_q     <= ok_i;
    end
    if (s2_load && s1_valid_q) begin
      s2_pw_q  <= PW_W'(s1_whole_q) * PW_W'(s1_wscale_q);
      s2_pf_q  <= PF_W'(s1_frac_q) * PF_W'(s1_fscale_q);
      s2_neg_q <= s1_neg_q;
      s2_ok_q  <= s1_ok_q;
    end
    if (out_load && s2_valid_q) begin
      value_q <= value_d;
      ok_q    <= ok_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign ok_o        = ok_q;

endmodule

/* rtl/core/decimal_text_to_fixed_point_unit.sv */
// Top level of the decimal text to fixed-point unit: register port, text parser and result pipeline.
`timescale 1ns / 1ps

// Converts decimal text, one ASCII character per request, into a signed scaled integer.
// A text is an optional '+' or '-', whole digits and an optional '.' with fraction digits;
// a request with end_of_text set closes it and yields one result, value = sign *
// (whole * 10^k + fraction) with k decimal places from the fraction_digits register
// (saturated to MAX_FRACTION_DIGITS), and ok low with value zero for a malformed text or
// a magnitude above 2000000000. Extra fraction digits are truncated. Character requests
// give no result. One request is taken every cycle while in_stall_o is low; each character
// updates the accumulators in the cycle it is taken, and a result passes from its end
// request through an operand register, a product register and the output register.
// A stalled output holds up to three pending results before the input stalls.
// fraction_digits sits at byte address 0 and may be rewritten between requests.
module decimal_text_to_fixed_point_unit
  import dtf_pkg::*;
#(
  parameter int unsigned MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // Character channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                char_code_i,
  input  logic                      end_of_text_i,
  // Result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      ok_o
);

  // Largest usable k is bounded both by the parameter and by the register width.
  localparam int unsigned K_MAX  = (MAX_FRACTION_DIGITS < (2**CFG_W - 1)) ?
                                   MAX_FRACTION_DIGITS : (2**CFG_W - 1);
  localparam int unsigned FRAC_W = $clog2(10**MAX_FRACTION_DIGITS);
  localparam int unsigned CNT_W  = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam int unsigned POW_W  = $clog2(10**K_MAX + 1);
  localparam int unsigned WX_W   = WHOLE_W + 4;

  // Configuration register.
  logic [CFG_W-1:0] fraction_digits_q;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_FRACTION_DIGITS);
  assign prdata    = (paddr[2] == REG_FRACTION_DIGITS) ? 32'(fraction_digits_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fraction_digits_q <= '0;
    end else if (cfg_write) begin
      fraction_digits_q <= pwdata[CFG_W-1:0];
    end
  end

  // Number state.
  phase_e             phase_q, phase_d;
  logic               negative_q, negative_d;
  logic [WHOLE_W-1:0] whole_q, whole_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               seen_q, seen_d;
  logic               failed_q, failed_d;

  // Fraction value after each number of kept digits, for truncation when k shrinks.
  logic [FRAC_W-1:0]  prefix_q [MAX_FRACTION_DIGITS+1];

  // Handshake and character decode.
  logic               req_stall;
  logic               accept;
  logic               take_char;
  logic               is_digit, is_sign, is_point;
  logic [3:0]         digit;
  logic [CNT_W-1:0]   k_cnt;
  logic [WX_W-1:0]    whole_next;
  logic               whole_over;
  logic               frac_keep;

  assign in_stall_o = req_stall;
  assign accept     = in_valid_i && !req_stall;
  assign take_char  = accept && !end_of_text_i && !failed_q;

  assign is_digit   = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
  assign is_sign    = (char_code_i == CHAR_PLUS) || (char_code_i == CHAR_MINUS);
  assign is_point   = (char_code_i == CHAR_POINT);
  assign digit      = 4'(char_code_i - CHAR_ZERO);

  // Effective decimal places, saturated to the parameter.
  assign k_cnt = (32'(fraction_digits_q) > MAX_FRACTION_DIGITS) ?
                 CNT_W'(MAX_FRACTION_DIGITS) : CNT_W'(fraction_digits_q);

  assign whole_next = (WX_W'(whole_q) << 3) + (WX_W'(whole_q) << 1) + WX_W'(digit);
  assign whole_over = whole_next > WX_W'(LIMIT);
  assign frac_keep  = take_char && is_digit && (phase_q == PH_FRAC) && (count_q < k_cnt);

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    if (accept && end_of_text_i) begin
      phase_d = PH_START;
    end else if (take_char) begin
      if (is_digit) begin
        if (phase_q != PH_FRAC) begin
          phase_d = PH_WHOLE;
        end
      end else if (is_sign && (phase_q == PH_START)) begin
        phase_d = PH_WHOLE;
      end else if (is_point && (phase_q != PH_FRAC)) begin
        phase_d = PH_FRAC;
      end
    end
  end

  // Accumulators and flags.
  always_comb begin
    negative_d = negative_q;
    whole_d    = whole_q;
    frac_d     = frac_q;
    count_d    = count_q;
    seen_d     = seen_q;
    failed_d   = failed_q;
    if (accept && end_of_text_i) begin
      negative_d = 1'b0;
      whole_d    = '0;
      frac_d     = '0;
      count_d    = '0;
      seen_d     = 1'b0;
      failed_d   = 1'b0;
    end else if (take_char) begin
      if (is_digit) begin
        seen_d = 1'b1;
        if (phase_q != PH_FRAC) begin
          if (whole_over) begin
            failed_d = 1'b1;
          end else begin
            whole_d = whole_next[WHOLE_W-1:0];
          end
        end else if (frac_keep) begin
          frac_d  = FRAC_W'((FRAC_W+4)'(frac_q) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit));
          count_d = count_q + CNT_W'(1);
        end
      end else if (is_sign && (phase_q == PH_START)) begin
        negative_d = (char_code_i == CHAR_MINUS);
      end else if (!(is_point && (phase_q != PH_FRAC))) begin
        failed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      negative_q <= 1'b0;
      whole_q    <= '0;
      frac_q     <= '0;
      count_q    <= '0;
      seen_q     <= 1'b0;
      failed_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      negative_q <= negative_d;
      whole_q    <= whole_d;
      frac_q     <= frac_d;
      count_q    <= count_d;
      seen_q     <= seen_d;
      failed_q   <= failed_d;
    end
  end

  // Record the fraction before each kept digit; entry j holds the first j digits.
  always_ff @(posedge clk_i) begin
    if (frac_keep) begin
      prefix_q[count_q] <= frac_q;
    end
  end

  // Operands of the end request: align the fraction to k places.
  logic               req_valid;
  logic [FRAC_W-1:0]  req_frac;
  logic [POW_W-1:0]   req_wscale, req_fscale;
  logic               req_ok;

  assign req_valid  = in_valid_i && end_of_text_i;
  assign req_ok     = seen_q && !failed_q;
  assign req_wscale = POW_W'(pow10(4'(k_cnt)));

  always_comb begin
    if (count_q <= k_cnt) begin
      req_frac   = frac_q;
      req_fscale = POW_W'(pow10(4'(k_cnt - count_q)));
    end else begin
      req_frac   = prefix_q[k_cnt];
      req_fscale = POW_W'(1);
    end
  end

  dtf_scale #(
    .FRAC_W (FRAC_W),
    .POW_W  (POW_W)
  ) u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_stall_o   (req_stall),
    .whole_i       (whole_q),
    .frac_i        (req_frac),
    .whole_scale_i (req_wscale),
    .frac_scale_i  (req_fscale),
    .negative_i    (negative_q),
    .ok_i          (req_ok),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .ok_o          (ok_o)
  );

endmodule
